/* rtl/cbc_pkg.sv */
// Shared types and constants for the circle to oriented box contact pipeline.
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [62:0] EPS_SQ =
        63'(((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000);
    localparam logic [33:0] MILLI = 34'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [17:0] NORM_ONE = 18'(64'd1 << FRAC_BITS);

    localparam int SQ_STAGES  = 16;
    localparam int QW         = FRAC_BITS + 1;
    localparam int NUM_W      = 31 + FRAC_BITS + 1;
    localparam int DIV_STAGES = (QW + 1) / 2;

    localparam int FRONT_STAGES = 9;
    localparam int SQ_FIRST     = FRONT_STAGES;
    localparam int DIV_FIRST    = SQ_FIRST + SQ_STAGES;
    localparam int OUT_STAGE    = DIV_FIRST + DIV_STAGES;
    localparam int NSTAGES      = OUT_STAGE + 1;

    typedef struct packed {
        logic        hit;
        logic        coin;
        logic        k;
        logic        sx;
        logic        sy;
        logic [30:0] ux;
        logic [30:0] uy;
        logic [30:0] r;
        logic [31:0] cx;
        logic [31:0] cy;
    } t_side;

endpackage

/* rtl/cbc_sqrt_pipe.sv */
// Pipelined integer square root, two result bits per stage.
`timescale 1ns / 1ps

module cbc_sqrt_pipe (
    input  logic                              i_clk,
    input  logic [cbc_pkg::SQ_STAGES-1:0]     i_en,
    input  logic [62:0]                       i_n,
    input  cbc_pkg::t_side                    i_side,
    output logic [31:0]                       o_root,
    output cbc_pkg::t_side                    o_side
);

    logic [33:0]    r_rem  [cbc_pkg::SQ_STAGES];
    logic [31:0]    r_root [cbc_pkg::SQ_STAGES];
    logic [63:0]    r_nb   [cbc_pkg::SQ_STAGES];
    cbc_pkg::t_side r_side [cbc_pkg::SQ_STAGES];

    genvar j;
    generate
        for (j = 0; j < cbc_pkg::SQ_STAGES; j++) begin : g_st
            localparam int PJ = (j == 0) ? 0 : j - 1;
            logic [33:0]    n_rem;
            logic [31:0]    n_root;
            logic [63:0]    n_nb;
            cbc_pkg::t_side n_side;

            always_comb begin
                logic [35:0] t;
                logic [35:0] trial;
                if (j == 0) begin
                    n_rem  = '0;
                    n_root = '0;
                    n_nb   = {1'b0, i_n};
                    n_side = i_side;
                end else begin
                    n_rem  = r_rem[PJ];
                    n_root = r_root[PJ];
                    n_nb   = r_nb[PJ];
                    n_side = r_side[PJ];
                end
                for (int s = 0; s < 2; s++) begin
                    t     = {n_rem, n_nb[63:62]};
                    trial = {2'b00, n_root, 2'b01};
                    if (t >= trial) begin
                        n_rem  = 34'(t - trial);
                        n_root = {n_root[30:0], 1'b1};
                    end else begin
                        n_rem  = t[33:0];
                        n_root = {n_root[30:0], 1'b0};
                    end
                    n_nb = {n_nb[61:0], 2'b00};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j]  <= n_rem;
                    r_root[j] <= n_root;
                    r_nb[j]   <= n_nb;
                    r_side[j] <= n_side;
                end
            end
        end
    endgenerate

    assign o_root = r_root[cbc_pkg::SQ_STAGES-1];
    assign o_side = r_side[cbc_pkg::SQ_STAGES-1];

endmodule

/* rtl/cbc_div_pipe.sv */
// Pipelined restoring dividers that divide both normal components by the length.
`timescale 1ns / 1ps

module cbc_div_pipe (
    input  logic                               i_clk,
    input  logic [cbc_pkg::DIV_STAGES-1:0]     i_en,
    input  logic [31:0]                        i_l,
    input  cbc_pkg::t_side                     i_side,
    output logic [cbc_pkg::QW-1:0]             o_qx,
    output logic [cbc_pkg::QW-1:0]             o_qy,
    output logic [31:0]                        o_l,
    output cbc_pkg::t_side                     o_side
);

    localparam int QW = cbc_pkg::QW;
    localparam int NW = cbc_pkg::NUM_W;

    logic [31:0]    r_remx [cbc_pkg::DIV_STAGES];
    logic [31:0]    r_remy [cbc_pkg::DIV_STAGES];
    logic [QW-1:0]  r_nbx  [cbc_pkg::DIV_STAGES];
    logic [QW-1:0]  r_nby  [cbc_pkg::DIV_STAGES];
    logic [QW-1:0]  r_qx   [cbc_pkg::DIV_STAGES];
    logic [QW-1:0]  r_qy   [cbc_pkg::DIV_STAGES];
    logic [31:0]    r_l    [cbc_pkg::DIV_STAGES];
    cbc_pkg::t_side r_side [cbc_pkg::DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < cbc_pkg::DIV_STAGES; j++) begin : g_st
            localparam int PJ = (j == 0) ? 0 : j - 1;
            logic [31:0]    n_remx, n_remy;
            logic [QW-1:0]  n_nbx, n_nby, n_qx, n_qy;
            logic [31:0]    n_l;
            cbc_pkg::t_side n_side;

            always_comb begin
                logic [NW-1:0] numx;
                logic [NW-1:0] numy;
                logic [32:0]   tx;
                logic [32:0]   ty;
                numx = {1'b0, i_side.ux, {cbc_pkg::FRAC_BITS{1'b0}}} + NW'(i_l[31:1]);
                numy = {1'b0, i_side.uy, {cbc_pkg::FRAC_BITS{1'b0}}} + NW'(i_l[31:1]);
                if (j == 0) begin
                    n_remx = 32'(numx[NW-1:QW]);
                    n_remy = 32'(numy[NW-1:QW]);
                    n_nbx  = numx[QW-1:0];
                    n_nby  = numy[QW-1:0];
                    n_qx   = '0;
                    n_qy   = '0;
                    n_l    = i_l;
                    n_side = i_side;
                end else begin
                    n_remx = r_remx[PJ];
                    n_remy = r_remy[PJ];
                    n_nbx  = r_nbx[PJ];
                    n_nby  = r_nby[PJ];
                    n_qx   = r_qx[PJ];
                    n_qy   = r_qy[PJ];
                    n_l    = r_l[PJ];
                    n_side = r_side[PJ];
                end
                for (int s = 0; s < 2; s++) begin
                    if (2 * j + s < QW) begin
                        tx = {n_remx, n_nbx[QW-1]};
                        ty = {n_remy, n_nby[QW-1]};
                        if (tx >= {1'b0, n_l}) begin
                            n_remx = 32'(tx - {1'b0, n_l});
                            n_qx   = {n_qx[QW-2:0], 1'b1};
                        end else begin
                            n_remx = tx[31:0];
                            n_qx   = {n_qx[QW-2:0], 1'b0};
                        end
                        if (ty >= {1'b0, n_l}) begin
                            n_remy = 32'(ty - {1'b0, n_l});
                            n_qy   = {n_qy[QW-2:0], 1'b1};
                        end else begin
                            n_remy = ty[31:0];
                            n_qy   = {n_qy[QW-2:0], 1'b0};
                        end
                        n_nbx = {n_nbx[QW-2:0], 1'b0};
                        n_nby = {n_nby[QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_remx[j] <= n_remx;
                    r_remy[j] <= n_remy;
                    r_nbx[j]  <= n_nbx;
                    r_nby[j]  <= n_nby;
                    r_qx[j]   <= n_qx;
                    r_qy[j]   <= n_qy;
                    r_l[j]    <= n_l;
                    r_side[j] <= n_side;
                end
            end
        end
    endgenerate

    assign o_qx   = r_qx[cbc_pkg::DIV_STAGES-1];
    assign o_qy   = r_qy[cbc_pkg::DIV_STAGES-1];
    assign o_l    = r_l[cbc_pkg::DIV_STAGES-1];
    assign o_side = r_side[cbc_pkg::DIV_STAGES-1];

endmodule

/* rtl/circle_box_contact_unit.sv */
// Top level of the circle to oriented box contact pipeline.
//
// channel   direction  fields (low bit up)
// s stream  in         circle_x, circle_y, circle_radius, box_x, box_y,
//                      box_half_width, box_half_height, box_cos, box_sin
// m stream  out        tdata: normal_x, normal_y, penetration, contact_x, contact_y
//                      tuser: hit
//
// One transaction is accepted per cycle while the output is not stalled; each result is
// presented from the 35th register stage.
// The pipeline is made of the 32-bit square root (16 stages) and the 17-bit
// normal dividers (9 stages) behind nine transform and compare stages.
// Each stage holds its data while the next one is full and stalled, so bubbles
// close up and a stall at the output loses or repeats nothing.
// Reset clears only the stage valid bits.
`timescale 1ns / 1ps

module circle_box_contact_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // circle_x, circle_y, circle_radius, box_x, box_y, box_half_width,
    // box_half_height, box_cos, box_sin, zero fill
    input  logic [263:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // normal_x, normal_y, penetration, contact_x, contact_y, zero fill
    output logic [135:0] o_m_tdata,
    // hit
    output logic         o_m_tuser
);

    localparam int FB = cbc_pkg::FRAC_BITS;
    localparam int NS = cbc_pkg::NSTAGES;

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [35:0] mag36(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    assign en[NS-1] = !r_vld[NS-1] || i_m_tready;
    genvar g;
    generate
        for (g = 0; g < NS - 1; g++) begin : g_en
            assign en[g] = !r_vld[g] || en[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    r_vld[i] <= (i == 0) ? i_s_tvalid : r_vld[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign o_s_tready = en[0];

    logic signed [31:0] in_cx, in_cy, in_bx, in_by;
    logic        [30:0] in_r, in_hw, in_hh;
    logic signed [17:0] in_c, in_s;
    assign in_cx = i_s_tdata[31:0];
    assign in_cy = i_s_tdata[63:32];
    assign in_r  = i_s_tdata[94:64];
    assign in_bx = i_s_tdata[126:95];
    assign in_by = i_s_tdata[158:127];
    assign in_hw = i_s_tdata[189:159];
    assign in_hh = i_s_tdata[220:190];
    assign in_c  = i_s_tdata[238:221];
    assign in_s  = i_s_tdata[256:239];

    // Stage 0: centre difference and rotation into the box frame.
    logic signed [50:0] r0_pcdx, r0_psdy, r0_pcdy, r0_psdx;
    logic signed [32:0] r0_dx, r0_dy;
    logic        [30:0] r0_hw, r0_hh, r0_r;
    logic signed [31:0] r0_bx, r0_by;
    logic signed [17:0] r0_c, r0_s;
    logic signed [32:0] n0_dx, n0_dy;
    assign n0_dx = 33'(in_cx) - 33'(in_bx);
    assign n0_dy = 33'(in_cy) - 33'(in_by);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_pcdx <= 51'(in_c) * 51'(n0_dx);
            r0_psdy <= 51'(in_s) * 51'(n0_dy);
            r0_pcdy <= 51'(in_c) * 51'(n0_dy);
            r0_psdx <= 51'(in_s) * 51'(n0_dx);
            r0_dx   <= n0_dx;
            r0_dy   <= n0_dy;
            r0_hw   <= in_hw;
            r0_hh   <= in_hh;
            r0_r    <= in_r;
            r0_bx   <= in_bx;
            r0_by   <= in_by;
            r0_c    <= in_c;
            r0_s    <= in_s;
        end
    end

    // Stage 1: round and clamp the local point.
    logic signed [31:0] r1_lx, r1_ly;
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [17:0] r1_c, r1_s;
    logic        [30:0] r1_r;
    logic signed [31:0] r1_bx, r1_by;
    logic signed [51:0] n1_sx, n1_sy;
    logic signed [35:0] n1_rx, n1_ry, n1_hw, n1_hh;
    logic signed [31:0] n1_lx, n1_ly;

    always_comb begin
        n1_sx = 52'(r0_pcdx) + 52'(r0_psdy) + (52'sd1 <<< (FB - 1));
        n1_sy = 52'(r0_pcdy) - 52'(r0_psdx) + (52'sd1 <<< (FB - 1));
        n1_rx = 36'(n1_sx >>> FB);
        n1_ry = 36'(n1_sy >>> FB);
        n1_hw = $signed({5'b0, r0_hw});
        n1_hh = $signed({5'b0, r0_hh});
        if (n1_rx > n1_hw) begin
            n1_lx = 32'(n1_hw);
        end else if (n1_rx < -n1_hw) begin
            n1_lx = 32'(-n1_hw);
        end else begin
            n1_lx = 32'(n1_rx);
        end
        if (n1_ry > n1_hh) begin
            n1_ly = 32'(n1_hh);
        end else if (n1_ry < -n1_hh) begin
            n1_ly = 32'(-n1_hh);
        end else begin
            n1_ly = 32'(n1_ry);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_lx <= n1_lx;
            r1_ly <= n1_ly;
            r1_dx <= r0_dx;
            r1_dy <= r0_dy;
            r1_c  <= r0_c;
            r1_s  <= r0_s;
            r1_r  <= r0_r;
            r1_bx <= r0_bx;
            r1_by <= r0_by;
        end
    end

    // Stage 2: rotation back to world space and centre distance squares.
    logic signed [49:0] r2_pclx, r2_psly, r2_pslx, r2_pcly;
    logic signed [32:0] r2_dx, r2_dy;
    logic        [61:0] r2_dxsq, r2_dysq;
    logic               r2_dsmall;
    logic        [30:0] r2_r;
    logic signed [31:0] r2_bx, r2_by;
    logic        [35:0] n2_mdx, n2_mdy;
    assign n2_mdx = mag36(36'(r1_dx));
    assign n2_mdy = mag36(36'(r1_dy));

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_pclx   <= 50'(r1_c) * 50'(r1_lx);
            r2_psly   <= 50'(r1_s) * 50'(r1_ly);
            r2_pslx   <= 50'(r1_s) * 50'(r1_lx);
            r2_pcly   <= 50'(r1_c) * 50'(r1_ly);
            r2_dxsq   <= 62'(n2_mdx[30:0]) * 62'(n2_mdx[30:0]);
            r2_dysq   <= 62'(n2_mdy[30:0]) * 62'(n2_mdy[30:0]);
            r2_dsmall <= (n2_mdx[35:31] == '0) && (n2_mdy[35:31] == '0);
            r2_dx     <= r1_dx;
            r2_dy     <= r1_dy;
            r2_r      <= r1_r;
            r2_bx     <= r1_bx;
            r2_by     <= r1_by;
        end
    end

    // Stage 3: world offset, contact offset and the coincident test.
    logic signed [34:0] r3_wx, r3_wy;
    logic signed [35:0] r3_ex, r3_ey;
    logic signed [32:0] r3_dx, r3_dy;
    logic               r3_coin;
    logic        [30:0] r3_r;
    logic signed [31:0] r3_bx, r3_by;
    logic signed [50:0] n3_sx, n3_sy;
    logic signed [34:0] n3_wx, n3_wy;
    logic        [62:0] n3_dsq;

    always_comb begin
        n3_sx  = 51'(r2_pclx) - 51'(r2_psly) + (51'sd1 <<< (FB - 1));
        n3_sy  = 51'(r2_pslx) + 51'(r2_pcly) + (51'sd1 <<< (FB - 1));
        n3_wx  = 35'(n3_sx >>> FB);
        n3_wy  = 35'(n3_sy >>> FB);
        n3_dsq = 63'(r2_dxsq) + 63'(r2_dysq);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_wx   <= n3_wx;
            r3_wy   <= n3_wy;
            r3_ex   <= 36'(r2_dx) - 36'(n3_wx);
            r3_ey   <= 36'(r2_dy) - 36'(n3_wy);
            r3_coin <= r2_dsmall && (n3_dsq <= cbc_pkg::EPS_SQ);
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_r    <= r2_r;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;
        end
    end

    // Stage 4: contact distance squares, radius square and contact point.
    logic        [61:0] r4_exsq, r4_eysq, r4_rr;
    logic               r4_far;
    logic signed [35:0] r4_ex, r4_ey;
    logic signed [32:0] r4_dx, r4_dy;
    logic               r4_coin;
    logic        [30:0] r4_r;
    logic        [31:0] r4_cx, r4_cy;
    logic        [35:0] n4_mex, n4_mey;
    assign n4_mex = mag36(r3_ex);
    assign n4_mey = mag36(r3_ey);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_exsq <= 62'(n4_mex[30:0]) * 62'(n4_mex[30:0]);
            r4_eysq <= 62'(n4_mey[30:0]) * 62'(n4_mey[30:0]);
            r4_rr   <= 62'(r3_r) * 62'(r3_r);
            r4_far  <= (n4_mex[35:31] != '0) || (n4_mey[35:31] != '0);
            r4_cx   <= sat32(36'(r3_bx) + 36'(r3_wx));
            r4_cy   <= sat32(36'(r3_by) + 36'(r3_wy));
            r4_ex   <= r3_ex;
            r4_ey   <= r3_ey;
            r4_dx   <= r3_dx;
            r4_dy   <= r3_dy;
            r4_coin <= r3_coin;
            r4_r    <= r3_r;
        end
    end

    // Stage 5: hit decision.
    logic               r5_hit, r5_small;
    logic signed [35:0] r5_ex, r5_ey;
    logic signed [32:0] r5_dx, r5_dy;
    logic               r5_coin;
    logic        [30:0] r5_r;
    logic        [31:0] r5_cx, r5_cy;
    logic        [62:0] n5_d2;
    assign n5_d2 = 63'(r4_exsq) + 63'(r4_eysq);

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_hit   <= !r4_far && (n5_d2 <= 63'(r4_rr));
            r5_small <= n5_d2 <= cbc_pkg::EPS_SQ;
            r5_ex    <= r4_ex;
            r5_ey    <= r4_ey;
            r5_dx    <= r4_dx;
            r5_dy    <= r4_dy;
            r5_coin  <= r4_coin;
            r5_r     <= r4_r;
            r5_cx    <= r4_cx;
            r5_cy    <= r4_cy;
        end
    end

    // Stage 6: pick the normal vector and scale it below 2^31.
    cbc_pkg::t_side     r6_side, n6_side;
    logic signed [35:0] n6_vx, n6_vy;
    logic        [35:0] n6_mx, n6_my;

    always_comb begin
        n6_vx        = r5_small ? 36'(r5_dx) : r5_ex;
        n6_vy        = r5_small ? 36'(r5_dy) : r5_ey;
        n6_mx        = mag36(n6_vx);
        n6_my        = mag36(n6_vy);
        n6_side.hit  = r5_hit;
        n6_side.coin = r5_coin;
        n6_side.k    = (n6_mx[35:31] != '0) || (n6_my[35:31] != '0);
        n6_side.sx   = n6_vx[35];
        n6_side.sy   = n6_vy[35];
        n6_side.ux   = n6_side.k ? n6_mx[31:1] : n6_mx[30:0];
        n6_side.uy   = n6_side.k ? n6_my[31:1] : n6_my[30:0];
        n6_side.r    = r5_r;
        n6_side.cx   = r5_cx;
        n6_side.cy   = r5_cy;
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_side <= n6_side;
        end
    end

    // Stages 7 and 8: squared length of the chosen vector.
    logic [61:0]    r7_uxsq, r7_uysq;
    cbc_pkg::t_side r7_side;
    logic [62:0]    r8_n;
    cbc_pkg::t_side r8_side;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_uxsq <= 62'(r6_side.ux) * 62'(r6_side.ux);
            r7_uysq <= 62'(r6_side.uy) * 62'(r6_side.uy);
            r7_side <= r6_side;
        end
        if (en[8]) begin
            r8_n    <= 63'(r7_uxsq) + 63'(r7_uysq);
            r8_side <= r7_side;
        end
    end

    logic [31:0]    sq_root;
    cbc_pkg::t_side sq_side;

    cbc_sqrt_pipe u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en[cbc_pkg::DIV_FIRST-1:cbc_pkg::SQ_FIRST]),
        .i_n    (r8_n),
        .i_side (r8_side),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    logic [cbc_pkg::QW-1:0] dv_qx, dv_qy;
    logic [31:0]            dv_l;
    cbc_pkg::t_side         dv_side;

    cbc_div_pipe u_div (
        .i_clk  (i_clk),
        .i_en   (en[cbc_pkg::OUT_STAGE-1:cbc_pkg::DIV_FIRST]),
        .i_l    (sq_root),
        .i_side (sq_side),
        .o_qx   (dv_qx),
        .o_qy   (dv_qy),
        .o_l    (dv_l),
        .o_side (dv_side)
    );

    // Output stage: normal, penetration and zeroing of misses.
    logic signed [17:0] r_nx, r_ny, n_nx, n_ny;
    logic        [31:0] r_pen, r_cx, r_cy, n_pen;
    logic               r_hit;
    logic        [33:0] n_len;

    always_comb begin
        if (dv_side.coin) begin
            n_nx  = cbc_pkg::NORM_ONE;
            n_ny  = '0;
            n_len = cbc_pkg::MILLI;
        end else begin
            n_len = dv_side.k ? {1'b0, dv_l, 1'b0} : {2'b00, dv_l};
            if (dv_l == '0) begin
                n_nx = '0;
                n_ny = '0;
            end else begin
                n_nx = dv_side.sx ? -18'(dv_qx) : 18'(dv_qx);
                n_ny = dv_side.sy ? -18'(dv_qy) : 18'(dv_qy);
            end
        end
        n_pen = sat32(36'($signed({5'b0, dv_side.r})) - 36'($signed({2'b00, n_len})));
    end

    always_ff @(posedge i_clk) begin
        if (en[cbc_pkg::OUT_STAGE]) begin
            r_hit <= dv_side.hit;
            r_nx  <= dv_side.hit ? n_nx : '0;
            r_ny  <= dv_side.hit ? n_ny : '0;
            r_pen <= dv_side.hit ? n_pen : '0;
            r_cx  <= dv_side.hit ? dv_side.cx : '0;
            r_cy  <= dv_side.hit ? dv_side.cy : '0;
        end
    end

    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = {4'b0000, r_cy, r_cx, r_pen, r_ny, r_nx};
    assign o_m_tuser  = r_hit;

endmodule

/* rtl/cbc_checker.sv */
// Port-level checks for the contact pipeline, bound to the top level.
`timescale 1ns / 1ps

module cbc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [135:0] o_m_tdata,
    input logic         o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss carries nonzero fields");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            ($signed(o_m_tdata[17:0]) <= 18'sd65536) &&
            ($signed(o_m_tdata[17:0]) >= -18'sd65536) &&
            ($signed(o_m_tdata[35:18]) <= 18'sd65536) &&
            ($signed(o_m_tdata[35:18]) >= -18'sd65536))
        else $error("normal component out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind circle_box_contact_unit cbc_checker u_cbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* tb/circle_box_contact_unit_test.sv */
// Self-checking testbench for the circle to oriented box contact unit.
`timescale 1ns / 1ps

module circle_box_contact_unit_test;

    localparam int FRAC_BITS = cbc_pkg::FRAC_BITS;

    localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
    localparam longint Q_ONE = longint'(1) << FRAC_BITS;
    localparam longint unsigned SQ_EPS = ((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000;
    localparam longint Q_MILLI = (Q_ONE + 500) / 1000;
    localparam longint unsigned BIG31 = 64'd1 << 31;
    localparam int N_RANDOM = 900;

    typedef struct packed {
        logic signed [17:0] sn;
        logic signed [17:0] cs;
        logic [30:0]        hh;
        logic [30:0]        hw;
        logic signed [31:0] by;
        logic signed [31:0] bx;
        logic [30:0]        r;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
    } t_pair;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pen;
        logic signed [17:0] ny;
        logic signed [17:0] nx;
    } t_contact;

    class t_contact_scoreboard;
        t_contact pending[$];
        int errors;
        int checked;
        int hits;

        function longint rnd_q(longint v);
            return (v + HALF_LSB) >>> FRAC_BITS;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void normalize(longint x, longint y, output longint nx, output longint ny,
                                output longint len);
            longint unsigned ux, uy, l, qx, qy;
            int k;
            ux = mag(x);
            uy = mag(y);
            k = 0;
            while ((ux >> k) >= BIG31 || (uy >> k) >= BIG31) k++;
            ux >>= k;
            uy >>= k;
            l = int_sqrt(ux * ux + uy * uy);
            len = longint'(l << k);
            if (l == 0) begin
                nx = 0;
                ny = 0;
                return;
            end
            qx = ((ux << FRAC_BITS) + l / 2) / l;
            qy = ((uy << FRAC_BITS) + l / 2) / l;
            nx = x < 0 ? -longint'(qx) : longint'(qx);
            ny = y < 0 ? -longint'(qy) : longint'(qy);
        endfunction

        function t_contact predict(t_pair p);
            t_contact o;
            longint c, s, dx, dy, lx, ly, wx, wy, ex, ey, nx, ny, len, r, hw, hh;
            longint unsigned d2, rr;
            bit coin;
            o = '0;
            c = longint'(p.cs);
            s = longint'(p.sn);
            r = longint'(p.r);
            hw = longint'(p.hw);
            hh = longint'(p.hh);
            dx = longint'(p.cx) - longint'(p.bx);
            dy = longint'(p.cy) - longint'(p.by);
            lx = rnd_q(c * dx + s * dy);
            ly = rnd_q(c * dy - s * dx);
            if (lx > hw) lx = hw;
            if (lx < -hw) lx = -hw;
            if (ly > hh) ly = hh;
            if (ly < -hh) ly = -hh;
            wx = rnd_q(c * lx - s * ly);
            wy = rnd_q(s * lx + c * ly);
            ex = dx - wx;
            ey = dy - wy;
            if (mag(ex) >= BIG31 || mag(ey) >= BIG31) return o;
            d2 = mag(ex) * mag(ex) + mag(ey) * mag(ey);
            rr = longint'(r) * longint'(r);
            if (d2 > rr) return o;
            coin = mag(dx) < BIG31 && mag(dy) < BIG31 &&
                   mag(dx) * mag(dx) + mag(dy) * mag(dy) <= SQ_EPS;
            if (coin) begin
                nx = Q_ONE;
                ny = 0;
                len = Q_MILLI;
            end else if (d2 <= SQ_EPS) begin
                normalize(dx, dy, nx, ny, len);
            end else begin
                normalize(ex, ey, nx, ny, len);
            end
            o.hit = 1'b1;
            o.nx = nx[17:0];
            o.ny = ny[17:0];
            o.pen = 32'(sat32(r - len));
            o.pos_x = 32'(sat32(longint'(p.bx) + wx));
            o.pos_y = 32'(sat32(longint'(p.by) + wy));
            return o;
        endfunction

        function void note_pair(t_pair p);
            pending.push_back(predict(p));
        endfunction

        function void compare(string name, longint e, longint a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_contact(t_contact a);
            t_contact e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, a);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.hit) hits++;
            compare("hit", e.hit, a.hit);
            compare("normal_x", e.nx, a.nx);
            compare("normal_y", e.ny, a.ny);
            compare("penetration", e.pen, a.pen);
            compare("contact_x", e.pos_x, a.pos_x);
            compare("contact_y", e.pos_y, a.pos_y);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [263:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [135:0] o_m_tdata;
    logic         o_m_tuser;

    t_contact_scoreboard sb;
    int tx_idle;
    int rx_idle;

    circle_box_contact_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_contact({o_m_tuser, o_m_tdata[131:0]});
        end
    end

    task automatic send_pair(t_pair p);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) >= tx_idle) break;
            i_s_tvalid <= 1'b0;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, p};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_pair(p);
    endtask

    task automatic send_fields(int cx, int cy, int r, int bx, int by, int hw, int hh,
                               int cs, int sn);
        t_pair p;
        p.cx = cx;
        p.cy = cy;
        p.r = r[30:0];
        p.bx = bx;
        p.by = by;
        p.hw = hw[30:0];
        p.hh = hh[30:0];
        p.cs = cs[17:0];
        p.sn = sn[17:0];
        send_pair(p);
    endtask

    task automatic send_random();
        t_pair p;
        real a;
        int cs, sn, bx, by, sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            p = t_pair'($bits(t_pair)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom}));
            if ($urandom_range(1)) p.cs = 18'($urandom_range(131072) - 65536);
            if ($urandom_range(1)) p.sn = 18'($urandom_range(131072) - 65536);
        end else begin
            a = $urandom_range(6283) / 1000.0;
            cs = $rtoi($cos(a) * 65536.0);
            sn = $rtoi($sin(a) * 65536.0);
            if (sel < 20) begin
                cs = 65536 * ($urandom_range(1) ? 1 : -1);
                sn = 0;
            end
            bx = int'($urandom_range(33554432)) - 16777216;
            by = int'($urandom_range(33554432)) - 16777216;
            p.bx = bx;
            p.by = by;
            p.hw = 31'($urandom_range(2097152));
            p.hh = 31'($urandom_range(2097152));
            p.cs = cs[17:0];
            p.sn = sn[17:0];
            p.r = 31'($urandom_range(4194304));
            if (sel < 28) begin
                p.cx = bx + int'($urandom_range(8)) - 4;
                p.cy = by + int'($urandom_range(8)) - 4;
            end else begin
                p.cx = bx + int'($urandom_range(8388608)) - 4194304;
                p.cy = by + int'($urandom_range(8388608)) - 4194304;
            end
        end
        send_pair(p);
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        tx_idle = 33;
        rx_idle = 56;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_fields(0, 0, 0, 0, 0, 0, 0, 65536, 0);
        send_fields(0, 0, 65536, 0, 0, 65536, 65536, 65536, 0);
        send_fields(2, -1, 65536, 0, 0, 65536, 65536, 65536, 0);
        send_fields(10000, 5000, 65536, 0, 0, 65536, 65536, 0, 65536);
        send_fields(200000, 0, 100000, 0, 0, 131072, 65536, 65536, 0);
        send_fields(200000, 0, 10000, 0, 0, 131072, 65536, 65536, 0);
        send_fields(150000, 150000, 131072, 0, 0, 65536, 65536, 46341, 46341);
        send_fields(-150000, 80000, 131072, 0, 0, 65536, 65536, -65536, 0);
        send_fields(0, 90000, 40000, 0, 0, 65536, 65536, 0, -65536);
        send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 65536, 0);
        send_fields(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    0, 0, -65536, -65536);
        send_fields(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFF000, 0, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 65536, 65536);
        send_fields(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 65536, 0);
        send_fields(32'h7FFF0000, 32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFF0000, 32'h7FFF0000,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 65536, 65536);
        send_fields(-1, -1, 1, 0, 0, 0, 0, -65536, 65536);
        send_fields(12345, -54321, 32'h7FFFFFFF, -1000, 2000, 32'h7FFFFFFF, 0, 0, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
                tx_idle = 56;
                rx_idle = 33;
            end
            if (i == 2 * N_RANDOM / 3) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            send_random();
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("Covered %0d pairs with %0d contacts: extremes, coincident and inside cases.",
                 sb.checked, sb.hits);
        $display("Stalls were applied on the input side, the output side, and neither.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
